// ===== src/ctprx_pkg.sv =====
// Shared types and constants for the CAN transport-session receiver.
// Holds the item, session state and result types used by ctprx_step and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package ctprx_pkg;

  // Size of the reassembly buffer in bytes; segments that would run past it are dropped.
  localparam int BUFFER_BYTES = 2048;
  localparam int BUF_LIMIT_W  = 17;

  localparam logic [15:0] RX_ID_RESET = 16'd22260;

  localparam logic [7:0] PF_DATA   = 8'hEB;
  localparam logic [7:0] PF_CONN   = 8'hEC;
  localparam logic [7:0] CTRL_RTS  = 8'h10;
  localparam logic [7:0] CTRL_CTS  = 8'h11;
  localparam logic [7:0] CTRL_ACK  = 8'h13;
  localparam logic [7:0] FILL_BYTE = 8'hFF;
  localparam logic [7:0] SEG_BYTES = 8'd7;

  typedef enum logic [1:0] {
    LINK_NORMAL      = 2'd0,
    LINK_CTS_PENDING = 2'd1,
    LINK_RECEIVING   = 2'd2,
    LINK_ACK_PENDING = 2'd3
  } link_state_t;

  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_TICK  = 1'b1
  } item_kind_t;

  typedef enum logic {
    RES_TX_FRAME = 1'b0,
    RES_SEGMENT  = 1'b1
  } res_kind_t;

  typedef struct packed {
    link_state_t  link_state;
    logic [7:0]   packets_expected;
    logic [7:0]   packets_received;
    logic [15:0]  session_size;
    logic [23:0]  session_group;
  } session_t;

  typedef struct packed {
    item_kind_t   kind;
    logic [28:0]  can_id;
    logic [63:0]  frame_data;
    logic         frame_valid;
    logic         buffer_busy;
  } item_t;

  typedef struct packed {
    res_kind_t    result_kind;
    logic [63:0]  payload;
    logic [10:0]  byte_offset;
    logic         last_segment;
    logic [23:0]  message_group;
    logic [15:0]  message_bytes;
  } result_t;

endpackage

// ===== src/can_transport_rts_cts_receiver.sv =====
// Receiver side of a CAN multi-packet transport session (request-to-send / clear-to-send).
//
// Input channel (in_valid/in_ready) carries one item per handshake: a received frame
// (kind 0) or a transmit opportunity tick (kind 1). Output channel (out_valid/out_ready)
// carries at most one result item per input item: a frame to transmit or a received
// data segment with its byte offset. cfg_we/cfg_data write the identifier match value.
//
// An accepted item is held in an input register while the session logic decodes it and
// updates the session registers; its result, if any, is then loaded into the output
// register. One item is taken every cycle while no output result waits to be taken:
// the single decode stage between the two registers sets this rate.
//
// When the output register holds a result that is not taken, the input register holds
// its item and in_ready drops once it is full; nothing is lost or repeated.
// Reset (rst, synchronous) empties both registers, returns the session to normal with
// all counters zero, and sets the identifier match value to 22260.
// Depends on ctprx_pkg and ctprx_step.
`timescale 1ns / 1ps

module can_transport_rts_cts_receiver (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ctprx_pkg::item_kind_t  kind,
  input  logic [28:0]            can_id,
  input  logic [63:0]            frame_data,
  input  logic                   frame_valid,
  input  logic                   buffer_busy,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ctprx_pkg::res_kind_t   result_kind,
  output logic [63:0]            payload,
  output logic [10:0]            byte_offset,
  output logic                   last_segment,
  output logic [23:0]            message_group,
  output logic [15:0]            message_bytes
);
  import ctprx_pkg::*;

  logic [15:0] rx_id;
  session_t    session;
  session_t    session_next;
  logic        s1_valid;
  item_t       s1_item;
  logic        s1_take;
  logic        step_valid;
  result_t     step_res;
  result_t     out_res;

  assign s1_take  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_id <= RX_ID_RESET;
    end else if (cfg_we) begin
      rx_id <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= '{kind: kind, can_id: can_id, frame_data: frame_data,
                   frame_valid: frame_valid, buffer_busy: buffer_busy};
    end
  end

  ctprx_step u_step (
    .st        (session),
    .item      (s1_item),
    .rx_id     (rx_id),
    .st_next   (session_next),
    .res_valid (step_valid),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      session <= '{link_state: LINK_NORMAL, packets_expected: 8'd0,
                   packets_received: 8'd0, session_size: 16'd0, session_group: 24'd0};
    end else if (s1_take) begin
      session <= session_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take) begin
      out_valid <= step_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && step_valid) begin
      out_res <= step_res;
    end
  end

  assign result_kind   = out_res.result_kind;
  assign payload       = out_res.payload;
  assign byte_offset   = out_res.byte_offset;
  assign last_segment  = out_res.last_segment;
  assign message_group = out_res.message_group;
  assign message_bytes = out_res.message_bytes;

  // A segment marked last leaves the session waiting to acknowledge.
  a_last_to_ack: assert property (@(posedge clk) disable iff (rst)
    (s1_take && step_valid && step_res.last_segment) |=>
      (session.link_state == LINK_ACK_PENDING))
    else $error("last segment did not move the session to acknowledge pending");

  // Transmit frames carry no offset and no last mark.
  a_tx_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == RES_TX_FRAME)) |-> ((byte_offset == 11'd0) && !last_segment))
    else $error("transmit frame with segment fields set");

  // A segment never reaches past the end of the buffer.
  a_seg_fits: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == RES_SEGMENT)) |->
      ((BUF_LIMIT_W'(byte_offset) + BUF_LIMIT_W'(SEG_BYTES)) <= BUF_LIMIT_W'(BUFFER_BYTES)))
    else $error("segment offset overflows the buffer");

  // The input side stalls only while the input register holds an item.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a blocked item");

endmodule

// ===== src/ctprx_step.sv =====
// Per-item decode for the CAN transport-session receiver: next session state and result.
// Purely combinational; uses the types and constants of ctprx_pkg.
`timescale 1ns / 1ps

module ctprx_step (
  input  ctprx_pkg::session_t st,
  input  ctprx_pkg::item_t    item,
  input  logic [15:0]         rx_id,
  output ctprx_pkg::session_t st_next,
  output logic                res_valid,
  output ctprx_pkg::result_t  res
);
  import ctprx_pkg::*;

  localparam logic [BUF_LIMIT_W-1:0] BUF_LIMIT = BUF_LIMIT_W'(BUFFER_BYTES);

  logic        id_match;
  logic        frame_ok;
  logic [7:0]  pf;
  logic [7:0]  seq;
  logic [10:0] seq_x7;
  logic [10:0] seg_offset;
  logic        seg_fits;
  logic        data_ok;
  logic [7:0]  rx_count_inc;
  logic        seg_last;
  logic [15:0] req_size;
  logic [7:0]  req_count;
  logic        rts_ok;
  logic        tick_cts;
  logic        tick_ack;

  assign id_match = (item.can_id[15:0] == rx_id);
  assign frame_ok = (item.kind == KIND_FRAME) && id_match && item.frame_valid;
  assign pf       = item.can_id[23:16];
  assign seq      = item.frame_data[7:0];

  // The end of a segment is seq*7; its start is that minus one segment.
  assign seq_x7     = {3'b000, seq} * 11'(SEG_BYTES);
  assign seg_offset = seq_x7 - 11'(SEG_BYTES);
  assign seg_fits   = (seq != 8'd0) && (BUF_LIMIT_W'(seq_x7) <= BUF_LIMIT);

  assign data_ok = frame_ok && (pf == PF_DATA) && (st.link_state != LINK_NORMAL) && seg_fits;

  assign rx_count_inc = (st.packets_received == 8'hFF) ? 8'hFF : st.packets_received + 8'd1;
  assign seg_last     = (rx_count_inc >= st.packets_expected);

  assign req_size  = item.frame_data[23:8];
  assign req_count = item.frame_data[31:24];
  assign rts_ok    = frame_ok && (pf == PF_CONN) && (item.frame_data[7:0] == CTRL_RTS)
                     && !item.buffer_busy && (req_size > 16'd8) && (req_count > 8'd1);

  assign tick_cts = (item.kind == KIND_TICK) && (st.link_state == LINK_CTS_PENDING);
  assign tick_ack = (item.kind == KIND_TICK) && (st.link_state == LINK_ACK_PENDING);

  // Next session state.
  always_comb begin
    st_next = st;
    if (tick_cts) begin
      st_next.link_state = LINK_RECEIVING;
    end else if (tick_ack) begin
      st_next.link_state = LINK_NORMAL;
    end else if (data_ok) begin
      st_next.packets_received = rx_count_inc;
      if (seg_last) begin
        st_next.link_state = LINK_ACK_PENDING;
      end
    end else if (rts_ok) begin
      st_next.link_state       = LINK_CTS_PENDING;
      st_next.packets_expected = req_count;
      st_next.packets_received = 8'd0;
      st_next.session_size     = req_size;
      st_next.session_group    = item.frame_data[63:40];
    end
  end

  // Result item.
  always_comb begin
    res_valid         = tick_cts || tick_ack || data_ok;
    res.result_kind   = RES_TX_FRAME;
    res.payload       = 64'd0;
    res.byte_offset   = 11'd0;
    res.last_segment  = 1'b0;
    res.message_group = st.session_group;
    res.message_bytes = st.session_size;
    if (tick_cts) begin
      res.payload = {st.session_group, FILL_BYTE, FILL_BYTE, 8'h01,
                     st.packets_expected, CTRL_CTS};
    end else if (tick_ack) begin
      res.payload = {st.session_group, FILL_BYTE, st.packets_expected,
                     st.session_size, CTRL_ACK};
    end else if (data_ok) begin
      res.result_kind  = RES_SEGMENT;
      res.payload      = {8'h00, item.frame_data[63:8]};
      res.byte_offset  = seg_offset;
      res.last_segment = seg_last;
    end
  end

endmodule

// ===== verif/can_transport_rts_cts_receiver_test.sv =====
// Self-checking testbench for the CAN transport-session receiver.
// Predicts every transmit frame and data segment in-line and checks each output item.
// Depends on ctprx_pkg and can_transport_rts_cts_receiver.
`timescale 1ns / 1ps

module can_transport_rts_cts_receiver_test;
  import ctprx_pkg::*;

  localparam int TOTAL_ITEMS  = 1550;
  localparam int DRAIN_CYCLES = 4;
  localparam int IDLE_LIMIT   = 2000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  item_kind_t  kind;
  logic [28:0] can_id;
  logic [63:0] frame_data;
  logic        frame_valid;
  logic        buffer_busy;
  logic        out_valid;
  logic        out_ready = 1'b1;
  res_kind_t   result_kind;
  logic [63:0] payload;
  logic [10:0] byte_offset;
  logic        last_segment;
  logic [23:0] message_group;
  logic [15:0] message_bytes;

  // Session state as the testbench expects the receiver to hold it.
  logic [15:0] exp_rx_id;
  link_state_t exp_link;
  logic [7:0]  exp_packets_total;
  logic [7:0]  exp_packets_seen;
  logic [15:0] exp_msg_size;
  logic [23:0] exp_msg_group;

  result_t pending_frames_segments[$];

  int  items_sent;
  int  mismatches;
  int  segments_checked;
  int  frames_checked;
  int  id_settings;
  int  idle_cycles;
  int  stall_left = 0;
  bit  gaps_on;
  bit  stalls_on;

  can_transport_rts_cts_receiver dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .can_id       (can_id),
    .frame_data   (frame_data),
    .frame_valid  (frame_valid),
    .buffer_busy  (buffer_busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .payload      (payload),
    .byte_offset  (byte_offset),
    .last_segment (last_segment),
    .message_group(message_group),
    .message_bytes(message_bytes)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Works out the item the receiver should emit for one accepted input item, if any,
  // and advances the expected session state.
  function automatic bit predict_session_output(input item_t it, output result_t res);
    logic [7:0]  pdu_format;
    logic [7:0]  first_byte;
    logic [15:0] req_size;
    logic [7:0]  req_count;
    int          offset;
    bit          produced;
    pdu_format = it.can_id[23:16];
    first_byte = it.frame_data[7:0];
    produced   = 1'b0;
    res        = '0;
    if (it.kind == KIND_TICK) begin
      if (exp_link == LINK_CTS_PENDING) begin
        res.result_kind = RES_TX_FRAME;
        res.payload     = {exp_msg_group, FILL_BYTE, FILL_BYTE, 8'h01, exp_packets_total,
                           CTRL_CTS};
        exp_link        = LINK_RECEIVING;
        produced        = 1'b1;
      end else if (exp_link == LINK_ACK_PENDING) begin
        res.result_kind = RES_TX_FRAME;
        res.payload     = {exp_msg_group, FILL_BYTE, exp_packets_total, exp_msg_size,
                           CTRL_ACK};
        exp_link        = LINK_NORMAL;
        produced        = 1'b1;
      end
    end else if (it.can_id[15:0] == exp_rx_id && it.frame_valid) begin
      if (pdu_format == PF_DATA) begin
        offset = (int'(first_byte) - 1) * int'(SEG_BYTES);
        if (exp_link != LINK_NORMAL && first_byte != 8'd0 &&
            offset + int'(SEG_BYTES) <= BUFFER_BYTES) begin
          if (exp_packets_seen != 8'hFF) exp_packets_seen = exp_packets_seen + 8'd1;
          res.result_kind  = RES_SEGMENT;
          res.payload      = {8'h00, it.frame_data[63:8]};
          res.byte_offset  = offset[10:0];
          res.last_segment = (exp_packets_seen >= exp_packets_total);
          if (res.last_segment) exp_link = LINK_ACK_PENDING;
          produced = 1'b1;
        end
      end else if (pdu_format == PF_CONN && first_byte == CTRL_RTS && !it.buffer_busy) begin
        req_size  = it.frame_data[23:8];
        req_count = it.frame_data[31:24];
        if (req_size > 16'd8 && req_count > 8'd1) begin
          exp_packets_total = req_count;
          exp_packets_seen  = 8'd0;
          exp_msg_size      = req_size;
          exp_msg_group     = it.frame_data[63:40];
          exp_link          = LINK_CTS_PENDING;
        end
      end
    end
    res.message_group = exp_msg_group;
    res.message_bytes = exp_msg_size;
    return produced;
  endfunction

  function automatic logic [28:0] frame_id(input logic [7:0] pdu_format, input logic [4:0] top);
    return {top, pdu_format, exp_rx_id};
  endfunction

  function automatic logic [63:0] request_bytes(input logic [15:0] size, input logic [7:0] count,
                                                input logic [23:0] group, input logic [7:0] ctrl);
    return {group, 8'($urandom), count, size, ctrl};
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Sends one item; valid stays up across back-to-back items.
  task automatic send_item(input item_kind_t k, input logic [28:0] id, input logic [63:0] d,
                           input logic fv, input logic bb);
    int      gap;
    item_t   it;
    result_t res;
    gap = (gaps_on && $urandom_range(0, 99) < 35) ? gap_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind        <= k;
    can_id      <= id;
    frame_data  <= d;
    frame_valid <= fv;
    buffer_busy <= bb;
    in_valid    <= 1'b1;
    it.kind        = k;
    it.can_id      = id;
    it.frame_data  = d;
    it.frame_valid = fv;
    it.buffer_busy = bb;
    do @(posedge clk); while (!in_ready);
    if (predict_session_output(it, res)) pending_frames_segments.push_back(res);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, 29'($urandom), {$urandom, $urandom}, 1'($urandom), 1'($urandom));
  endtask

  task automatic send_segment(input logic [7:0] seq, input logic [55:0] bytes);
    send_item(KIND_FRAME, frame_id(PF_DATA, 5'($urandom)), {bytes, seq}, 1'b1, 1'b0);
  endtask

  // Stops sending and waits until the receiver has nothing left in flight.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_frames_segments.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_rx_id(input logic [15:0] value);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    exp_rx_id = value;
    id_settings++;
  endtask

  // Items that should mostly be dropped or ignored.
  task automatic send_noise();
    logic [28:0] id;
    logic [7:0]  ctrl;
    case ($urandom_range(0, 5))
      0: send_tick();
      1: begin
        id = 29'($urandom);
        if (id[15:0] == exp_rx_id) id[0] = ~id[0];
        send_item(KIND_FRAME, id, {$urandom, $urandom}, 1'($urandom), 1'($urandom));
      end
      2: send_item(KIND_FRAME, frame_id(8'($urandom), 5'($urandom)), {$urandom, $urandom},
                   1'b0, 1'($urandom));
      3: send_item(KIND_FRAME, frame_id(8'($urandom), 5'($urandom)), {$urandom, $urandom},
                   1'b1, 1'($urandom));
      4: begin
        if ($urandom_range(0, 1) == 0)
          send_item(KIND_FRAME, frame_id(PF_CONN, 5'($urandom)),
                    request_bytes(16'($urandom_range(0, 8)), 8'($urandom), 24'($urandom),
                                  CTRL_RTS), 1'b1, 1'b0);
        else
          send_item(KIND_FRAME, frame_id(PF_CONN, 5'($urandom)),
                    request_bytes(16'($urandom), 8'($urandom_range(0, 1)), 24'($urandom),
                                  CTRL_RTS), 1'b1, 1'b0);
      end
      default: begin
        ctrl = 8'($urandom);
        if (ctrl == CTRL_RTS) ctrl = FILL_BYTE;
        send_item(KIND_FRAME, frame_id(PF_CONN, 5'($urandom)),
                  request_bytes(16'($urandom), 8'($urandom), 24'($urandom), ctrl),
                  1'b1, 1'($urandom));
      end
    endcase
  endtask

  // A well-formed session with random content, now and then broken or interleaved.
  task automatic random_session();
    int          count;
    int          n_data;
    int          i;
    int          r;
    logic [15:0] size;
    logic [7:0]  seq;
    count = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 255) : $urandom_range(2, 10);
    size  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(9, 16))
                                        : 16'($urandom_range(9, 65535));
    send_item(KIND_FRAME, frame_id(PF_CONN, 5'($urandom)),
              request_bytes(size, 8'(count), 24'($urandom), CTRL_RTS), 1'b1,
              $urandom_range(0, 9) == 0);
    if ($urandom_range(0, 9) != 0) send_tick();
    n_data = count - 1 + $urandom_range(0, 3);
    for (i = 1; i <= n_data; i++) begin
      r = $urandom_range(0, 99);
      if (r < 85) seq = 8'(i);
      else if (r < 90) seq = 8'd0;
      else seq = 8'($urandom);
      send_segment(seq, {$urandom, 24'($urandom)});
      if ($urandom_range(0, 19) == 0) send_noise();
      if ($urandom_range(0, 29) == 0) send_tick();
    end
    if ($urandom_range(0, 9) != 0) send_tick();
  endtask

  task automatic test_directed_cases();
    // A tick and a data frame while no session is open, then requests that must be refused.
    send_tick();
    send_item(KIND_FRAME, frame_id(PF_DATA, 5'h00), {56'h0, 8'd1}, 1'b1, 1'b0);
    send_item(KIND_FRAME, frame_id(PF_CONN, 5'h00),
              request_bytes(16'd100, 8'd4, 24'h123456, CTRL_RTS), 1'b1, 1'b1);
    send_item(KIND_FRAME, frame_id(PF_CONN, 5'h00),
              request_bytes(16'd8, 8'd5, 24'h123456, CTRL_RTS), 1'b1, 1'b0);
    send_item(KIND_FRAME, frame_id(PF_CONN, 5'h00),
              request_bytes(16'd9, 8'd1, 24'h123456, CTRL_RTS), 1'b1, 1'b0);
    send_item(KIND_FRAME, frame_id(PF_CONN, 5'h00),
              request_bytes(16'd100, 8'd4, 24'h123456, FILL_BYTE), 1'b1, 1'b0);
    send_item(KIND_FRAME, frame_id(PF_CONN, 5'h00),
              request_bytes(16'd100, 8'd4, 24'h123456, CTRL_CTS), 1'b1, 1'b0);
    send_item(KIND_FRAME, frame_id(PF_CONN, 5'h00),
              request_bytes(16'd100, 8'd4, 24'h123456, CTRL_ACK), 1'b1, 1'b0);
    // Largest request; a segment arrives before the clear-to-send goes out.
    send_item(KIND_FRAME, frame_id(PF_CONN, 5'h1F),
              request_bytes(16'hFFFF, 8'd2, 24'hFFFFFF, CTRL_RTS), 1'b1, 1'b0);
    send_item(KIND_FRAME, frame_id(PF_DATA, 5'h1F), {56'hFF_FFFF_FFFF_FFFF, 8'd1}, 1'b1, 1'b0);
    send_tick();
    send_tick();
    send_segment(8'd0, 56'h11_2233_4455_6677);
    send_item(KIND_FRAME, 29'h0, {56'h0, 8'd2}, 1'b1, 1'b0);
    send_item(KIND_FRAME, frame_id(PF_DATA, 5'h00), {56'h0, 8'd2}, 1'b0, 1'b0);
    send_item(KIND_FRAME, frame_id(8'hEA, 5'h00), {56'h0, 8'd2}, 1'b1, 1'b0);
    // A new request in the middle of a session starts over.
    send_item(KIND_FRAME, frame_id(PF_CONN, 5'h00),
              request_bytes(16'd9, 8'd3, 24'h000000, CTRL_RTS), 1'b1, 1'b0);
    send_item(KIND_FRAME, frame_id(PF_DATA, 5'h1F), 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    send_segment(8'd2, 56'h0);
    send_segment(8'd3, 56'hA5_A5A5_A5A5_A5A5);
    send_segment(8'd4, 56'h5A_5A5A_5A5A_5A5A);
    send_tick();
    send_tick();
  endtask

  // Identifier match values at both ends of the range, then back to the previous one.
  task automatic test_rx_id_extremes();
    logic [15:0] old_id;
    old_id    = exp_rx_id;
    gaps_on   = 1'b1;
    stalls_on = 1'b0;
    write_rx_id(16'h0000);
    random_session();
    send_noise();
    write_rx_id(16'hFFFF);
    random_session();
    send_noise();
    write_rx_id(old_id);
  endtask

  task automatic test_pause_mid_session();
    int i;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_item(KIND_FRAME, frame_id(PF_CONN, 5'($urandom)),
              request_bytes(16'd42, 8'd6, 24'($urandom), CTRL_RTS), 1'b1, 1'b0);
    send_tick();
    for (i = 1; i <= 3; i++) send_segment(8'(i), {$urandom, 24'($urandom)});
    wait_drained();
    for (i = 4; i <= 6; i++) send_segment(8'(i), {$urandom, 24'($urandom)});
    send_tick();
  endtask

  // More segments than announced, so the received count saturates.
  task automatic test_count_saturation();
    int i;
    gaps_on   = 1'b0;
    stalls_on = 1'b1;
    send_item(KIND_FRAME, frame_id(PF_CONN, 5'($urandom)),
              request_bytes(16'd1785, 8'd255, 24'($urandom), CTRL_RTS), 1'b1, 1'b0);
    send_tick();
    for (i = 1; i <= 258; i++) send_segment(8'((i - 1) % 255 + 1), {$urandom, 24'($urandom)});
    send_tick();
  endtask

  task automatic test_random_traffic();
    int phase_end;
    while (items_sent < TOTAL_ITEMS) begin
      phase_end = items_sent + 150;
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 2) == 0) write_rx_id(16'($urandom));
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else random_session();
        if ($urandom_range(0, 24) == 0) wait_drained();
      end
    end
  endtask

  // The output side: stalls out_ready, checks each item and runs the watchdog.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (stalls_on && $urandom_range(0, 3) == 0) stall_left = gap_length();
    end
  end

  always @(posedge clk) begin : output_check
    result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_frames_segments.size() == 0) begin
          $error("output item with none expected: payload %0h", payload);
          mismatches++;
        end else begin
          want = pending_frames_segments.pop_front();
          check_field("result_kind", want.result_kind, result_kind);
          check_field("payload", want.payload, payload);
          check_field("byte_offset", want.byte_offset, byte_offset);
          check_field("last_segment", want.last_segment, last_segment);
          check_field("message_group", want.message_group, message_group);
          check_field("message_bytes", want.message_bytes, message_bytes);
          if (want.result_kind == RES_SEGMENT) segments_checked++;
          else frames_checked++;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_data    = 16'h0;
    in_valid    = 1'b0;
    kind        = KIND_FRAME;
    can_id      = 29'h0;
    frame_data  = 64'h0;
    frame_valid = 1'b0;
    buffer_busy = 1'b0;
    gaps_on     = 1'b0;
    stalls_on   = 1'b0;
    exp_rx_id         = RX_ID_RESET;
    exp_link          = LINK_NORMAL;
    exp_packets_total = 8'd0;
    exp_packets_seen  = 8'd0;
    exp_msg_size      = 16'd0;
    exp_msg_group     = 24'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_rx_id_extremes();
    test_pause_mid_session();
    test_count_saturation();
    test_random_traffic();
    write_rx_id(RX_ID_RESET);
    random_session();
    wait_drained();

    if (pending_frames_segments.size() != 0) begin
      $error("%0d expected output items never arrived", pending_frames_segments.size());
      mismatches++;
    end
    $display("Sent %0d items over %0d identifier settings; checked %0d segments and %0d frames.",
             items_sent, id_settings, segments_checked, frames_checked);
    $display("Mismatches found: %0d", mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
